/* rtl/core/sdrms_pkg.sv */
// Shared types and constants for the successive-difference RMS block.
package sdrms_pkg;

  localparam int SUM_W     = 48;
  localparam int CNT_W     = 25;
  localparam int QDEPTH    = 4;
  localparam int QPW       = 2;
  localparam int QLW       = 3;
  localparam int DIV_STEPS = 48;
  localparam int ROOT_W    = 24;
  localparam int STEP_W    = 6;
  localparam int RMS_W     = 16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_FEW  = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms_value;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t entry;
  } q_head_t;

endpackage

/* rtl/core/sdrms_front.sv */
// Front end: sample transfer, squared difference pipeline and record accumulation.
module sdrms_front #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  sdrms_pkg::in_t          item,
  input  logic [sdrms_pkg::QLW-1:0] level,
  output logic                    push,
  output sdrms_pkg::rec_t         entry
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = (SAMPLE_BITS > 16) ? 17 : SAMPLE_BITS;
  localparam int TB = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
  localparam int SW = sdrms_pkg::SUM_W;

  logic signed [PW-1:0] prev;
  logic [CW-1:0]        count;
  logic                 ovf;

  logic                 s1_valid, s1_last, s1_add, s1_ovf;
  logic [PW-1:0]        s1_mag;
  logic [CW-1:0]        s1_cnt;

  logic                 s2_valid, s2_last, s2_add, s2_ovf;
  logic [2*PW-1:0]      s2_sq;
  logic [CW-1:0]        s2_cnt;

  logic [SW-1:0]        sum;
  logic [SW-1:0]        sum_next;
  logic [SW:0]          sum_wide;

  logic [16:0]          ext;
  logic signed [PW-1:0] sw;
  logic signed [PW:0]   diff;
  logic [PW-1:0]        mag;
  logic                 cap_ok;
  logic                 accept;
  logic [CW-1:0]        count_upd;
  logic                 ovf_upd;
  logic [sdrms_pkg::QLW:0] reserve;

  always_comb begin
    ext = (SAMPLE_BITS > 16) ? {1'b0, item.sample} : 17'(signed'(item.sample[TB-1:0]));
    sw = signed'(ext[PW-1:0]);
    diff = (PW+1)'(sw) - (PW+1)'(prev);
    mag = diff[PW] ? PW'(-diff) : diff[PW-1:0];
    cap_ok = count < CW'(MAX_SAMPLES);
    count_upd = cap_ok ? count + CW'(1) : count;
    ovf_upd = ovf | ~cap_ok;
    accept = item_valid && !item_stall;
  end

  always_comb begin
    sum_wide = {1'b0, sum} + (SW+1)'(s2_sq);
    if (s2_add) begin
      sum_next = sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
    end else begin
      sum_next = sum;
    end
  end

  always_comb begin
    reserve = {1'b0, level}
            + (sdrms_pkg::QLW+1)'(s1_valid && s1_last)
            + (sdrms_pkg::QLW+1)'(s2_valid && s2_last);
    item_stall = reserve >= (sdrms_pkg::QLW+1)'(sdrms_pkg::QDEPTH);
    push = s2_valid && s2_last;
    entry.sum = sum_next;
    entry.count = sdrms_pkg::CNT_W'(s2_cnt);
    entry.overflow = s2_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      count <= '0;
      ovf <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      sum <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        s1_last <= item.last;
        s1_add <= cap_ok && (count != '0);
        s1_mag <= mag;
        s1_cnt <= count_upd;
        s1_ovf <= ovf_upd;
        if (item.last) begin
          prev <= '0;
          count <= '0;
          ovf <= 1'b0;
        end else begin
          count <= count_upd;
          ovf <= ovf_upd;
          if (cap_ok) begin
            prev <= sw;
          end
        end
      end
      s2_valid <= s1_valid;
      s2_last <= s1_last;
      s2_add <= s1_add;
      s2_sq <= (2*PW)'(s1_mag) * (2*PW)'(s1_mag);
      s2_cnt <= s1_cnt;
      s2_ovf <= s1_ovf;
      if (s2_valid) begin
        sum <= s2_last ? '0 : sum_next;
      end
    end
  end

endmodule

/* rtl/core/sdrms_queue.sv */
// Record queue between the front end and the back end.
module sdrms_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  sdrms_pkg::rec_t             entry,
  input  logic                        pop,
  output sdrms_pkg::q_head_t          head,
  output logic [sdrms_pkg::QLW-1:0]   level
);

  sdrms_pkg::rec_t mem [sdrms_pkg::QDEPTH];
  logic [sdrms_pkg::QPW-1:0] wr_ptr;
  logic [sdrms_pkg::QPW-1:0] rd_ptr;
  logic [sdrms_pkg::QLW-1:0] fill;

  always_comb begin
    head.valid = fill != '0;
    head.entry = mem[rd_ptr];
    level = fill;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sdrms_pkg::QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sdrms_pkg::QPW'(1);
      end
      fill <= fill + sdrms_pkg::QLW'(push) - sdrms_pkg::QLW'(pop);
    end
  end

endmodule

/* rtl/core/sdrms_back.sv */
// Back end: serial divide, serial square root and result register.
module sdrms_back (
  input  logic                clk,
  input  logic                rst,
  input  sdrms_pkg::q_head_t  head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output sdrms_pkg::out_t     result
);

  localparam int SW    = sdrms_pkg::SUM_W;
  localparam int CW    = sdrms_pkg::CNT_W;
  localparam int RW    = sdrms_pkg::ROOT_W;
  localparam int REM_W = (CW + 1 > RW + 2) ? CW + 1 : RW + 2;

  typedef enum logic [1:0] {
    IDLE,
    DIVIDE,
    ROOT,
    HOLD
  } state_t;

  state_t                      state;
  logic [SW-1:0]               dq;
  logic [CW-1:0]               divisor;
  logic [REM_W-1:0]            rem;
  logic [RW-1:0]               root;
  logic [sdrms_pkg::STEP_W-1:0] step;
  sdrms_pkg::out_t             res;

  logic [CW:0]                 div_shift;
  logic                        div_ge;
  logic [REM_W+1:0]            rt_shift;
  logic [REM_W+1:0]            rt_trial;
  logic                        rt_ge;
  logic [RW-1:0]               root_nx;
  logic                        load;

  always_comb begin
    div_shift = {rem[CW-1:0], dq[SW-1]};
    div_ge = div_shift >= {1'b0, divisor};
    rt_shift = {rem, dq[SW-1:SW-2]};
    rt_trial = (REM_W+2)'({root, 2'b01});
    rt_ge = rt_shift >= rt_trial;
    root_nx = {root[RW-2:0], rt_ge};
    pop = (state == IDLE) && head.valid;
    load = (state == HOLD) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (head.valid) begin
            if (head.entry.overflow) begin
              res.rms_value <= '0;
              res.status <= sdrms_pkg::STATUS_TOO_LONG;
              state <= HOLD;
            end else if (head.entry.count < CW'(2)) begin
              res.rms_value <= '0;
              res.status <= sdrms_pkg::STATUS_TOO_FEW;
              state <= HOLD;
            end else begin
              dq <= head.entry.sum;
              divisor <= head.entry.count - CW'(1);
              rem <= '0;
              step <= '0;
              state <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          dq <= {dq[SW-2:0], div_ge};
          if (step == sdrms_pkg::STEP_W'(sdrms_pkg::DIV_STEPS - 1)) begin
            rem <= '0;
            root <= '0;
            step <= '0;
            state <= ROOT;
          end else begin
            rem <= REM_W'(div_ge ? div_shift - {1'b0, divisor} : div_shift);
            step <= step + sdrms_pkg::STEP_W'(1);
          end
        end
        ROOT: begin
          rem <= REM_W'(rt_ge ? rt_shift - rt_trial : rt_shift);
          root <= root_nx;
          dq <= {dq[SW-3:0], 2'b00};
          step <= step + sdrms_pkg::STEP_W'(1);
          if (step == sdrms_pkg::STEP_W'(RW - 1)) begin
            res.rms_value <= (root_nx[RW-1:sdrms_pkg::RMS_W] != '0)
                           ? {sdrms_pkg::RMS_W{1'b1}} : root_nx[sdrms_pkg::RMS_W-1:0];
            res.status <= sdrms_pkg::STATUS_OK;
            state <= HOLD;
          end
        end
        HOLD: begin
          if (load) begin
            result <= res;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/successive_difference_rms.sv */
// Top level of the successive-difference RMS block.
// Throughput: one sample per cycle unless stalled; records queue up to four deep ahead of the back end.
// Path from the last sample's transfer to result_valid with the back end free: stages s1, s2,
// the queue hand-off, 48 divide steps, 24 root steps, then the load into the result register.
// Records hold the back end in DIVIDE and ROOT (errors skip both); short bursts stall input.
// Reset: synchronous rst clears the front-end counters, the queue and the result valid flag.
module successive_difference_rms #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sdrms_pkg::in_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sdrms_pkg::out_t  result
);

  logic                            push;
  logic                            pop;
  sdrms_pkg::rec_t                 entry;
  sdrms_pkg::q_head_t              head;
  logic [sdrms_pkg::QLW-1:0]       level;

  sdrms_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .level(level),
    .push(push),
    .entry(entry)
  );

  sdrms_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .entry(entry),
    .pop(pop),
    .head(head),
    .level(level)
  );

  sdrms_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .pop(pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

endmodule

/* rtl/core/sdrms_checker.sv */
// Port-level checks for the successive-difference RMS block, bound to the top level.
module sdrms_assert (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sdrms_pkg::in_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input sdrms_pkg::out_t  result
);

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !item_stall)
    else $error("outputs active after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status == sdrms_pkg::STATUS_OK
                  || result.status == sdrms_pkg::STATUS_TOO_FEW
                  || result.status == sdrms_pkg::STATUS_TOO_LONG)
    else $error("unknown status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != sdrms_pkg::STATUS_OK |-> result.rms_value == '0)
    else $error("error result carries a value");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("input changed while stalled");

endmodule

bind successive_difference_rms sdrms_assert u_sdrms_assert (
  .clk(clk),
  .rst(rst),
  .item_valid(item_valid),
  .item_stall(item_stall),
  .item(item),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result(result)
);
